// ===== hdl/usb_enum_pkg.sv =====
// Shared types and constants for the USB enumeration sequencer.
// No dependencies; imported by every module of the block.
package usb_enum_pkg;

  // Sizes
  localparam int BUFFER_BYTES = 512;
  localparam int MAX_ADDRESS  = 127;
  localparam int ADDR_W       = 7;
  localparam int ADDR_SLOTS   = 1 << ADDR_W;
  localparam int LEN_W        = 10;
  localparam int POS_W        = 10;
  localparam int CAPT_BYTES   = 18;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Input actions
  localparam logic [1:0] ACT_START    = 2'd0;
  localparam logic [1:0] ACT_DATA     = 2'd1;
  localparam logic [1:0] ACT_COMPLETE = 2'd2;
  localparam logic [1:0] ACT_RELEASE  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_SETUP   = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_NO_ADDR = 2'd2;

  // Setup request fields
  localparam logic [7:0]  RT_GET_DESC    = 8'h80;
  localparam logic [7:0]  RT_NONE        = 8'h00;
  localparam logic [7:0]  REQ_GET_DESC   = 8'd6;
  localparam logic [7:0]  REQ_SET_ADDR   = 8'd5;
  localparam logic [7:0]  REQ_SET_CONFIG = 8'd9;
  localparam logic [15:0] DESC_DEVICE    = 16'h0100;
  localparam logic [15:0] DESC_CONFIG    = 16'h0200;
  localparam logic [15:0] DESC_STRING    = 16'h0300;
  localparam logic [7:0]  STRING_TYPE    = 8'd3;
  localparam logic [7:0]  LANG_MIN_LEN   = 8'd4;
  localparam logic [LEN_W-1:0] LEN_DEV_SHORT = LEN_W'(8);
  localparam logic [LEN_W-1:0] LEN_DEV_FULL  = LEN_W'(18);
  localparam logic [LEN_W-1:0] LEN_CFG_HDR   = LEN_W'(9);
  localparam logic [LEN_W-1:0] LEN_STRING    = LEN_W'(BUFFER_BYTES - 4);
  localparam logic [15:0]      CFG_LIMIT     = 16'(BUFFER_BYTES);

  // Phases
  localparam logic [3:0] PH_DEV8   = 4'd0;
  localparam logic [3:0] PH_ADDR   = 4'd1;
  localparam logic [3:0] PH_DEV18  = 4'd2;
  localparam logic [3:0] PH_LANG   = 4'd4;
  localparam logic [3:0] PH_STR0   = 4'd6;
  localparam logic [3:0] PH_STR1   = 4'd8;
  localparam logic [3:0] PH_STR2   = 4'd10;
  localparam logic [3:0] PH_CFGH   = 4'd12;
  localparam logic [3:0] PH_CFG    = 4'd13;
  localparam logic [3:0] PH_SETCFG = 4'd14;
  localparam logic [3:0] PH_IDLE   = 4'd15;

  // Allocator control and status
  typedef struct packed {
    logic              claim;
    logic              release_addr;
    logic [ADDR_W-1:0] freed;
  } alloc_ctl_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] last_given;
  } alloc_stat_t;

  // One result item
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        request_type;
    logic [7:0]        request_code;
    logic [15:0]       setup_value;
    logic [15:0]       setup_index;
    logic [LEN_W-1:0]  setup_length;
    logic [ADDR_W-1:0] device_address;
    logic [7:0]        max_packet_size;
    logic [15:0]       vendor_id;
    logic [15:0]       product_id;
    logic [7:0]        device_class;
    logic [7:0]        max_power;
  } result_t;

endpackage

// ===== hdl/usb_enum_alloc.sv =====
// Device address allocator: in-use bitmap and rotating priority search.
// Depends on usb_enum_pkg.
module usb_enum_alloc (
  input  logic                     clk,
  input  logic                     rst,
  input  usb_enum_pkg::alloc_ctl_t ctl,
  output usb_enum_pkg::alloc_stat_t stat
);
  import usb_enum_pkg::*;

  logic [ADDR_SLOTS-1:0] used;
  logic [ADDR_W-1:0]     last_given;
  logic [ADDR_SLOTS-1:0] free_mask;
  logic [ADDR_SLOTS-1:0] above;
  logic [ADDR_SLOTS-1:0] pick;
  logic [ADDR_SLOTS-1:0] lowest;
  logic [ADDR_W-1:0]     found_addr;

  // Free addresses 1..MAX_ADDRESS, split at the last one handed out
  always_comb begin
    for (int i = 0; i < ADDR_SLOTS; i++) begin
      free_mask[i] = !used[i] && (i >= 1) && (i <= MAX_ADDRESS);
      above[i]     = free_mask[i] && (ADDR_W'(i) > last_given);
    end
    pick   = (|above) ? above : free_mask;
    lowest = pick & (~pick + 1'b1);
  end

  // One-hot to index
  always_comb begin
    found_addr = '0;
    for (int i = 0; i < ADDR_SLOTS; i++) begin
      if (lowest[i]) begin
        found_addr = found_addr | ADDR_W'(i);
      end
    end
  end

  assign stat.found      = |free_mask;
  assign stat.address    = found_addr;
  assign stat.last_given = last_given;

  // Bitmap and round-robin pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      last_given <= '0;
    end else if (ctl.claim) begin
      used[found_addr] <= 1'b1;
      last_given       <= found_addr;
    end else if (ctl.release_addr) begin
      used[ctl.freed] <= 1'b0;
    end
  end

endmodule

// ===== hdl/usb_enum_core.sv =====
// Enumeration phase sequencer: descriptor capture and setup packet build.
// Depends on usb_enum_pkg; drives usb_enum_alloc through alloc_ctl_t.
module usb_enum_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [1:0]                        action,
  input  logic [7:0]                        data_byte,
  input  logic [usb_enum_pkg::ADDR_W-1:0]   freed_address,
  input  usb_enum_pkg::alloc_stat_t         alloc_stat,
  output usb_enum_pkg::alloc_ctl_t          alloc_ctl,
  output logic                              push,
  output usb_enum_pkg::result_t             res
);
  import usb_enum_pkg::*;

  logic [3:0]        phase, phase_next;
  logic              busy, busy_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]        captured [CAPT_BYTES];
  logic [7:0]        string_idx [3];
  logic [7:0]        string_idx_next [3];
  logic [15:0]       language_id, language_id_next;
  logic [ADDR_W-1:0] current_address, current_address_next;
  logic [7:0]        max_packet_size, max_packet_size_next;
  logic [15:0]       vendor_id, vendor_id_next;
  logic [15:0]       product_id, product_id_next;
  logic [7:0]        device_class, device_class_next;
  logic [7:0]        max_power, max_power_next;
  logic              store_byte;
  logic [15:0]       cfg_total;
  logic [LEN_W-1:0]  cfg_len;
  logic [1:0]        str_from;
  logic              str_ask;

  // Config length, clamped to the buffer
  always_comb begin
    cfg_total = {captured[3], captured[2]};
    cfg_len   = (cfg_total > CFG_LIMIT) ? CFG_LIMIT[LEN_W-1:0] : cfg_total[LEN_W-1:0];
  end

  // Starting string slot for the current phase
  always_comb begin
    case (phase)
      PH_STR0: str_from = 2'd1;
      PH_STR1: str_from = 2'd2;
      default: str_from = 2'd0;
    endcase
  end

  // Next-state and result
  always_comb begin
    phase_next           = phase;
    busy_next            = busy;
    byte_position_next   = byte_position;
    string_idx_next      = string_idx;
    language_id_next     = language_id;
    current_address_next = current_address;
    max_packet_size_next = max_packet_size;
    vendor_id_next       = vendor_id;
    product_id_next      = product_id;
    device_class_next    = device_class;
    max_power_next       = max_power;
    store_byte           = 1'b0;
    str_ask              = 1'b0;
    alloc_ctl            = '0;
    alloc_ctl.freed      = freed_address;
    push                 = 1'b0;
    res                  = '0;

    if (accept) begin
      case (action)
        ACT_START: begin
          busy_next            = 1'b1;
          current_address_next = '0;
          max_packet_size_next = '0;
          vendor_id_next       = '0;
          product_id_next      = '0;
          device_class_next    = '0;
          max_power_next       = '0;
          string_idx_next      = '{default: '0};
          language_id_next     = '0;
          push                 = 1'b1;
          res.request_type     = RT_GET_DESC;
          res.request_code     = REQ_GET_DESC;
          res.setup_value      = DESC_DEVICE;
          res.setup_length     = LEN_DEV_SHORT;
          phase_next           = PH_DEV8;
        end
        ACT_DATA: begin
          if (busy) begin
            store_byte = byte_position < POS_W'(CAPT_BYTES);
            if (byte_position != POS_MAX) begin
              byte_position_next = byte_position + 1'b1;
            end
          end
        end
        ACT_RELEASE: begin
          alloc_ctl.release_addr = 1'b1;
        end
        default: begin
          if (busy) begin
            case (phase)
              PH_DEV8: begin
                max_packet_size_next = captured[7];
                push = 1'b1;
                if (!alloc_stat.found) begin
                  res.kind   = KIND_NO_ADDR;
                  phase_next = PH_IDLE;
                  busy_next  = 1'b0;
                end else begin
                  alloc_ctl.claim  = 1'b1;
                  res.request_code = REQ_SET_ADDR;
                  res.setup_value  = 16'(alloc_stat.address);
                  phase_next       = PH_ADDR;
                end
              end
              PH_ADDR: begin
                current_address_next = alloc_stat.last_given;
                push             = 1'b1;
                res.request_type = RT_GET_DESC;
                res.request_code = REQ_GET_DESC;
                res.setup_value  = DESC_DEVICE;
                res.setup_length = LEN_DEV_FULL;
                phase_next       = PH_DEV18;
              end
              PH_DEV18: begin
                vendor_id_next     = {captured[9], captured[8]};
                product_id_next    = {captured[11], captured[10]};
                device_class_next  = captured[4];
                string_idx_next[0] = captured[14];
                string_idx_next[1] = captured[15];
                string_idx_next[2] = captured[16];
                push             = 1'b1;
                res.request_type = RT_GET_DESC;
                res.request_code = REQ_GET_DESC;
                if ((captured[14] | captured[15] | captured[16]) != 8'd0) begin
                  res.setup_value  = DESC_STRING;
                  res.setup_length = LEN_STRING;
                  phase_next       = PH_LANG;
                end else begin
                  res.setup_value  = DESC_CONFIG;
                  res.setup_length = LEN_CFG_HDR;
                  phase_next       = PH_CFGH;
                end
              end
              PH_LANG: begin
                push             = 1'b1;
                res.request_type = RT_GET_DESC;
                res.request_code = REQ_GET_DESC;
                if (captured[0] < LANG_MIN_LEN || captured[1] != STRING_TYPE) begin
                  res.setup_value  = DESC_CONFIG;
                  res.setup_length = LEN_CFG_HDR;
                  phase_next       = PH_CFGH;
                end else begin
                  language_id_next = {captured[3], captured[2]};
                  str_ask          = 1'b1;
                end
              end
              PH_STR0, PH_STR1: begin
                push             = 1'b1;
                res.request_type = RT_GET_DESC;
                res.request_code = REQ_GET_DESC;
                str_ask          = 1'b1;
              end
              PH_STR2: begin
                push             = 1'b1;
                res.request_type = RT_GET_DESC;
                res.request_code = REQ_GET_DESC;
                res.setup_value  = DESC_CONFIG;
                res.setup_length = LEN_CFG_HDR;
                phase_next       = PH_CFGH;
              end
              PH_CFGH: begin
                push             = 1'b1;
                res.request_type = RT_GET_DESC;
                res.request_code = REQ_GET_DESC;
                res.setup_value  = DESC_CONFIG;
                res.setup_length = cfg_len;
                phase_next       = PH_CFG;
              end
              PH_CFG: begin
                max_power_next   = captured[8];
                push             = 1'b1;
                res.request_code = REQ_SET_CONFIG;
                res.setup_value  = 16'(captured[5]);
                phase_next       = PH_SETCFG;
              end
              PH_SETCFG: begin
                push       = 1'b1;
                res.kind   = KIND_DONE;
                phase_next = PH_IDLE;
                busy_next  = 1'b0;
              end
              default: begin
                push = 1'b0;
              end
            endcase

            // Next non-empty string slot, else the config header
            if (str_ask) begin
              if (str_from == 2'd0 && string_idx[0] != 8'd0) begin
                res.setup_value = DESC_STRING | 16'(string_idx[0]);
                res.setup_index = language_id_next;
                res.setup_length = LEN_STRING;
                phase_next = PH_STR0;
              end else if (str_from != 2'd2 && string_idx[1] != 8'd0) begin
                res.setup_value = DESC_STRING | 16'(string_idx[1]);
                res.setup_index = language_id_next;
                res.setup_length = LEN_STRING;
                phase_next = PH_STR1;
              end else if (string_idx[2] != 8'd0) begin
                res.setup_value = DESC_STRING | 16'(string_idx[2]);
                res.setup_index = language_id_next;
                res.setup_length = LEN_STRING;
                phase_next = PH_STR2;
              end else begin
                res.setup_value  = DESC_CONFIG;
                res.setup_length = LEN_CFG_HDR;
                phase_next       = PH_CFGH;
              end
            end
          end
        end
      endcase
    end

    // Captured fields reflect this item's updates; any result restarts the byte count
    res.device_address  = current_address_next;
    res.max_packet_size = max_packet_size_next;
    res.vendor_id       = vendor_id_next;
    res.product_id      = product_id_next;
    res.device_class    = device_class_next;
    res.max_power       = max_power_next;
    if (push) begin
      byte_position_next = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      busy            <= 1'b0;
      byte_position   <= '0;
      captured        <= '{default: '0};
      string_idx      <= '{default: '0};
      language_id     <= '0;
      current_address <= '0;
      max_packet_size <= '0;
      vendor_id       <= '0;
      product_id      <= '0;
      device_class    <= '0;
      max_power       <= '0;
    end else begin
      phase           <= phase_next;
      busy            <= busy_next;
      byte_position   <= byte_position_next;
      string_idx      <= string_idx_next;
      language_id     <= language_id_next;
      current_address <= current_address_next;
      max_packet_size <= max_packet_size_next;
      vendor_id       <= vendor_id_next;
      product_id      <= product_id_next;
      device_class    <= device_class_next;
      max_power       <= max_power_next;
      if (store_byte) begin
        captured[byte_position[4:0]] <= data_byte;
      end
    end
  end

endmodule

// ===== hdl/usb_enum_outbuf.sv =====
// Output register with one skid entry for result items.
// Depends on usb_enum_pkg (result_t).
module usb_enum_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  usb_enum_pkg::result_t push_data,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output usb_enum_pkg::result_t out_data
);
  import usb_enum_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  // New items are taken only while the skid entry is empty
  assign space = !skid_valid;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (push) begin
      out_data <= push_data;
    end
  end

endmodule

// ===== hdl/usb_enumeration_sequencer.sv =====
// USB enumeration sequencer, top level. A result item is registered in the output
// register, or in the skid entry while that register is stalled, once its input item is accepted.
// Throughput: one input item per cycle; in_ready drops only while the skid
// entry of the output buffer holds a result behind a stalled output register.
// Reset (rst, synchronous): phase idle, address bitmap clear, captured bytes zero,
// no result pending. Depends on usb_enum_pkg, usb_enum_alloc, usb_enum_core, usb_enum_outbuf.
module usb_enumeration_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      action,
  input  logic [7:0]                      data_byte,
  input  logic [usb_enum_pkg::ADDR_W-1:0] freed_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      kind,
  output logic [7:0]                      request_type,
  output logic [7:0]                      request_code,
  output logic [15:0]                     setup_value,
  output logic [15:0]                     setup_index,
  output logic [usb_enum_pkg::LEN_W-1:0]  setup_length,
  output logic [usb_enum_pkg::ADDR_W-1:0] device_address,
  output logic [7:0]                      max_packet_size,
  output logic [15:0]                     vendor_id,
  output logic [15:0]                     product_id,
  output logic [7:0]                      device_class,
  output logic [7:0]                      max_power
);
  import usb_enum_pkg::*;

  logic        accept;
  logic        push;
  result_t     res;
  result_t     out_data;
  alloc_ctl_t  alloc_ctl;
  alloc_stat_t alloc_stat;

  assign accept = in_valid && in_ready;

  usb_enum_alloc u_alloc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alloc_ctl),
    .stat (alloc_stat)
  );

  usb_enum_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .action        (action),
    .data_byte     (data_byte),
    .freed_address (freed_address),
    .alloc_stat    (alloc_stat),
    .alloc_ctl     (alloc_ctl),
    .push          (push),
    .res           (res)
  );

  usb_enum_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Result fields
  assign kind            = out_data.kind;
  assign request_type    = out_data.request_type;
  assign request_code    = out_data.request_code;
  assign setup_value     = out_data.setup_value;
  assign setup_index     = out_data.setup_index;
  assign setup_length    = out_data.setup_length;
  assign device_address  = out_data.device_address;
  assign max_packet_size = out_data.max_packet_size;
  assign vendor_id       = out_data.vendor_id;
  assign product_id      = out_data.product_id;
  assign device_class    = out_data.device_class;
  assign max_power       = out_data.max_power;

endmodule

// ===== hdl/usb_enum_checker.sv =====
// Port-level checks for usb_enumeration_sequencer, with the bind that attaches them.
// Depends on usb_enum_pkg.
module usb_enum_assertions (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      kind,
  input logic [7:0]                      request_type,
  input logic [7:0]                      request_code,
  input logic [15:0]                     setup_value,
  input logic [15:0]                     setup_index,
  input logic [usb_enum_pkg::LEN_W-1:0]  setup_length
);
  import usb_enum_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(setup_value))
    else $error("stalled result changed");

  // Backpressure only with a result pending
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result pending");

  // Done and no-address results carry no setup request
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DONE || kind == KIND_NO_ADDR) |->
      request_type == RT_NONE && request_code == 8'd0 && setup_value == 16'd0 &&
      setup_index == 16'd0 && setup_length == '0)
    else $error("non-setup result with setup fields");

  // Set address carries a legal nonzero address
  a_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SETUP && request_code == REQ_SET_ADDR |->
      setup_value != 16'd0 && setup_value <= 16'(MAX_ADDRESS))
    else $error("set address out of range");

  // Setup packets never ask for more than the buffer
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SETUP |-> 16'(setup_length) <= CFG_LIMIT)
    else $error("setup length beyond buffer");

endmodule

bind usb_enumeration_sequencer usb_enum_assertions u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .request_type (request_type),
  .request_code (request_code),
  .setup_value  (setup_value),
  .setup_index  (setup_index),
  .setup_length (setup_length)
);

// ===== bench/usb_enum_checker.sv =====
`timescale 1ns / 100ps
// Result checker for usb_enumeration_sequencer: tracks the enumeration state from
// accepted input items and compares every result item field by field.
// Depends on usb_enum_pkg.
module usb_enum_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      action,
  input  logic [7:0]                      data_byte,
  input  logic [usb_enum_pkg::ADDR_W-1:0] freed_address,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [1:0]                      kind,
  input  logic [7:0]                      request_type,
  input  logic [7:0]                      request_code,
  input  logic [15:0]                     setup_value,
  input  logic [15:0]                     setup_index,
  input  logic [usb_enum_pkg::LEN_W-1:0]  setup_length,
  input  logic [usb_enum_pkg::ADDR_W-1:0] device_address,
  input  logic [7:0]                      max_packet_size,
  input  logic [15:0]                     vendor_id,
  input  logic [15:0]                     product_id,
  input  logic [7:0]                      device_class,
  input  logic [7:0]                      max_power,
  output int                              mismatches,
  output int                              backlog
);
  import usb_enum_pkg::*;

  // Mirror of the enumeration state
  logic [3:0]            phase;
  logic                  enum_busy;
  logic [ADDR_SLOTS-1:0] addr_taken;
  logic [ADDR_W-1:0]     last_addr;
  logic [ADDR_W-1:0]     cur_addr;
  logic [POS_W-1:0]      byte_pos;
  logic [7:0]            rx_bytes [CAPT_BYTES];
  logic [7:0]            str_idx [3];
  logic [15:0]           lang_id;
  logic [LEN_W-1:0]      cfg_total;
  logic [7:0]            mps;
  logic [15:0]           vid;
  logic [15:0]           pid;
  logic [7:0]            dclass;
  logic [7:0]            mpower;

  result_t expected_packets[$];

  task automatic clear_enum_state();
    phase      = PH_IDLE;
    enum_busy  = 1'b0;
    addr_taken = '0;
    last_addr  = '0;
    cur_addr   = '0;
    byte_pos   = '0;
    foreach (rx_bytes[i]) rx_bytes[i] = '0;
    foreach (str_idx[i]) str_idx[i] = '0;
    lang_id    = '0;
    cfg_total  = '0;
    {mps, vid, pid, dclass, mpower} = '0;
  endtask

  // Queue one result carrying what is known of the device; restarts byte capture
  task automatic push_packet(logic [1:0] k, logic [7:0] rt, logic [7:0] rc,
                             logic [15:0] val, logic [15:0] idx, logic [LEN_W-1:0] len);
    result_t r;
    r.kind            = k;
    r.request_type    = rt;
    r.request_code    = rc;
    r.setup_value     = val;
    r.setup_index     = idx;
    r.setup_length    = len;
    r.device_address  = cur_addr;
    r.max_packet_size = mps;
    r.vendor_id       = vid;
    r.product_id      = pid;
    r.device_class    = dclass;
    r.max_power       = mpower;
    expected_packets.push_back(r);
    byte_pos = '0;
  endtask

  task automatic get_desc(logic [15:0] val, logic [15:0] idx, logic [LEN_W-1:0] len,
                          logic [3:0] next_phase);
    push_packet(KIND_SETUP, RT_GET_DESC, REQ_GET_DESC, val, idx, len);
    phase = next_phase;
  endtask

  task automatic ask_config_header();
    get_desc(DESC_CONFIG, '0, LEN_CFG_HDR, PH_CFGH);
  endtask

  // First string slot from 'first' on with a non-zero index, else the config header
  task automatic ask_string_from(int first);
    for (int s = first; s < 3; s++) begin
      if (str_idx[s] != 0) begin
        get_desc(DESC_STRING | {8'h00, str_idx[s]}, lang_id, LEN_STRING,
                 s == 0 ? PH_STR0 : (s == 1 ? PH_STR1 : PH_STR2));
        return;
      end
    end
    ask_config_header();
  endtask

  // Round-robin search after the last address handed out; zero when all taken
  function automatic logic [ADDR_W-1:0] next_free_address();
    int a;
    a = last_addr;
    for (int n = 0; n < MAX_ADDRESS; n++) begin
      a++;
      if (a > MAX_ADDRESS) a = 1;
      if (!addr_taken[a]) return ADDR_W'(a);
    end
    return '0;
  endfunction

  // Transfer complete: move to the next request
  task automatic advance_phase();
    logic [ADDR_W-1:0] a;
    int total;
    case (phase)
      PH_DEV8: begin
        mps = rx_bytes[7];
        a = next_free_address();
        if (a == '0) begin
          push_packet(KIND_NO_ADDR, RT_NONE, '0, '0, '0, '0);
          phase     = PH_IDLE;
          enum_busy = 1'b0;
        end else begin
          addr_taken[a] = 1'b1;
          last_addr     = a;
          push_packet(KIND_SETUP, RT_NONE, REQ_SET_ADDR, 16'(a), '0, '0);
          phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        cur_addr = last_addr;
        get_desc(DESC_DEVICE, '0, LEN_DEV_FULL, PH_DEV18);
      end
      PH_DEV18: begin
        vid    = {rx_bytes[9], rx_bytes[8]};
        pid    = {rx_bytes[11], rx_bytes[10]};
        dclass = rx_bytes[4];
        for (int s = 0; s < 3; s++) str_idx[s] = rx_bytes[14 + s];
        if ((str_idx[0] | str_idx[1] | str_idx[2]) != 0)
          get_desc(DESC_STRING, '0, LEN_STRING, PH_LANG);
        else
          ask_config_header();
      end
      PH_LANG: begin
        // bad language reply skips all strings
        if (rx_bytes[0] < LANG_MIN_LEN || rx_bytes[1] != STRING_TYPE) begin
          ask_config_header();
        end else begin
          lang_id = {rx_bytes[3], rx_bytes[2]};
          ask_string_from(0);
        end
      end
      PH_STR0: ask_string_from(1);
      PH_STR1: ask_string_from(2);
      PH_STR2: ask_config_header();
      PH_CFGH: begin
        total = {rx_bytes[3], rx_bytes[2]};
        if (total > BUFFER_BYTES) total = BUFFER_BYTES;
        cfg_total = LEN_W'(total);
        get_desc(DESC_CONFIG, '0, cfg_total, PH_CFG);
      end
      PH_CFG: begin
        mpower = rx_bytes[8];
        push_packet(KIND_SETUP, RT_NONE, REQ_SET_CONFIG, {8'h00, rx_bytes[5]}, '0, '0);
        phase = PH_SETCFG;
      end
      PH_SETCFG: begin
        push_packet(KIND_DONE, RT_NONE, '0, '0, '0, '0);
        phase     = PH_IDLE;
        enum_busy = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic enumerate_step(logic [1:0] act, logic [7:0] rx, logic [ADDR_W-1:0] freed);
    case (act)
      ACT_START: begin
        // restart drops everything but the address bitmap, the last address handed out and the received bytes
        enum_busy = 1'b1;
        cur_addr  = '0;
        {mps, vid, pid, dclass, mpower} = '0;
        foreach (str_idx[i]) str_idx[i] = '0;
        lang_id   = '0;
        cfg_total = '0;
        get_desc(DESC_DEVICE, '0, LEN_DEV_SHORT, PH_DEV8);
      end
      ACT_DATA: begin
        if (enum_busy) begin
          if (byte_pos < CAPT_BYTES) rx_bytes[byte_pos] = rx;
          if (byte_pos != POS_MAX) byte_pos++;
        end
      end
      ACT_COMPLETE: begin
        if (enum_busy) advance_phase();
      end
      ACT_RELEASE: addr_taken[freed] = 1'b0;
      default: ;
    endcase
  endtask

  function automatic bit field_off(string name, logic [15:0] want, logic [15:0] got);
    if (want === got) return 1'b0;
    if (mismatches < 10)
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    return 1'b1;
  endfunction

  task automatic check_packet();
    result_t want;
    bit bad;
    if (expected_packets.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: result item with none expected, kind %0d", $time, kind);
      mismatches++;
      return;
    end
    want = expected_packets.pop_front();
    bad = 1'b0;
    bad |= field_off("kind", 16'(want.kind), 16'(kind));
    bad |= field_off("request_type", 16'(want.request_type), 16'(request_type));
    bad |= field_off("request_code", 16'(want.request_code), 16'(request_code));
    bad |= field_off("setup_value", want.setup_value, setup_value);
    bad |= field_off("setup_index", want.setup_index, setup_index);
    bad |= field_off("setup_length", 16'(want.setup_length), 16'(setup_length));
    bad |= field_off("device_address", 16'(want.device_address), 16'(device_address));
    bad |= field_off("max_packet_size", 16'(want.max_packet_size), 16'(max_packet_size));
    bad |= field_off("vendor_id", want.vendor_id, vendor_id);
    bad |= field_off("product_id", want.product_id, product_id);
    bad |= field_off("device_class", 16'(want.device_class), 16'(device_class));
    bad |= field_off("max_power", 16'(want.max_power), 16'(max_power));
    if (bad) mismatches++;
  endtask

  // Outputs checked before the same edge's input is predicted
  always @(posedge clk) begin
    if (rst) begin
      clear_enum_state();
      expected_packets.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) check_packet();
      if (in_valid && in_ready) enumerate_step(action, data_byte, freed_address);
    end
    backlog = expected_packets.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the usb_enumeration_sequencer bench: clock, reset, stimulus and verdict.
// Depends on usb_enum_pkg, the block itself and usb_enum_checker.
module testbench;
  import usb_enum_pkg::*;

  typedef logic [7:0] octets_t[$];

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        action;
  logic [7:0]        data_byte;
  logic [ADDR_W-1:0] freed_address;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        kind;
  logic [7:0]        request_type;
  logic [7:0]        request_code;
  logic [15:0]       setup_value;
  logic [15:0]       setup_index;
  logic [LEN_W-1:0]  setup_length;
  logic [ADDR_W-1:0] device_address;
  logic [7:0]        max_packet_size;
  logic [15:0]       vendor_id;
  logic [15:0]       product_id;
  logic [7:0]        device_class;
  logic [7:0]        max_power;
  int                mismatches;
  int                backlog;

  int gap_pct   = 0;
  int stall_pct = 0;
  int items_sent = 0;

  usb_enumeration_sequencer DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .data_byte       (data_byte),
    .freed_address   (freed_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .request_type    (request_type),
    .request_code    (request_code),
    .setup_value     (setup_value),
    .setup_index     (setup_index),
    .setup_length    (setup_length),
    .device_address  (device_address),
    .max_packet_size (max_packet_size),
    .vendor_id       (vendor_id),
    .product_id      (product_id),
    .device_class    (device_class),
    .max_power       (max_power)
  );

  usb_enum_checker packet_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .data_byte       (data_byte),
    .freed_address   (freed_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .request_type    (request_type),
    .request_code    (request_code),
    .setup_value     (setup_value),
    .setup_index     (setup_index),
    .setup_length    (setup_length),
    .device_address  (device_address),
    .max_packet_size (max_packet_size),
    .vendor_id       (vendor_id),
    .product_id      (product_id),
    .device_class    (device_class),
    .max_power       (max_power),
    .mismatches      (mismatches),
    .backlog         (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #3_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Receiver: random stall bursts at the rate the stimulus sets
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rnd_addr();
    return ADDR_W'($urandom);
  endfunction

  // One item; returns at the edge where it is accepted
  task automatic send_item(logic [1:0] act, logic [7:0] rx, logic [ADDR_W-1:0] freed);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    data_byte     <= rx;
    freed_address <= freed;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_octets(octets_t d);
    foreach (d[i]) send_item(ACT_DATA, d[i], rnd_addr());
  endtask

  // Transfer complete, now and then followed by a release or a random item
  task automatic finish_transfer();
    send_item(ACT_COMPLETE, 8'($urandom), rnd_addr());
    if ($urandom_range(0, 9) == 0)
      send_item(ACT_RELEASE, 8'($urandom), rnd_addr());
    if ($urandom_range(0, 24) == 0)
      send_item(2'($urandom), 8'($urandom), rnd_addr());
  endtask

  // Mostly the nominal length, sometimes short, sometimes long
  function automatic octets_t random_octets(int nominal);
    octets_t d;
    int n;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      n = $urandom_range(0, nominal);
    else if (pick == 1)
      n = nominal + $urandom_range(1, 8);
    else
      n = nominal;
    repeat (n) d.push_back(8'($urandom));
    return d;
  endfunction

  function automatic logic [7:0] string_slot();
    return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  // Well-formed enumeration with random content; sometimes cut short
  task automatic enumerate_device();
    octets_t d;
    int stop_at;
    int total;
    bit strings;
    bit lang_ok;
    logic [7:0] idx [3];
    stop_at = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 7) : 99;
    send_item(ACT_START, 8'($urandom), rnd_addr());
    // short device descriptor
    send_octets(random_octets(8));
    finish_transfer();
    if (stop_at == 1) return;
    // set address done
    finish_transfer();
    if (stop_at == 2) return;
    // full device descriptor with string indexes
    d = random_octets(18);
    for (int s = 0; s < 3; s++) begin
      idx[s] = string_slot();
      if (d.size() > 14 + s) d[14 + s] = idx[s];
    end
    strings = (idx[0] | idx[1] | idx[2]) != 0;
    send_octets(d);
    finish_transfer();
    if (stop_at == 3) return;
    if (strings) begin
      d = random_octets(4);
      lang_ok = $urandom_range(0, 6) != 0;
      if (d.size() > 1) begin
        if (lang_ok) begin
          d[0] = 8'($urandom_range(4, 255));
          d[1] = STRING_TYPE;
        end else if ($urandom_range(0, 1) == 0) begin
          d[0] = 8'($urandom_range(0, 3));
        end else begin
          d[1] = 8'($urandom) ^ STRING_TYPE;
          if (d[1] == STRING_TYPE) d[1] = 8'h00;
        end
      end
      send_octets(d);
      finish_transfer();
      if (stop_at == 4) return;
      if (lang_ok) begin
        for (int s = 0; s < 3; s++) begin
          if (idx[s] != 0) begin
            send_octets(random_octets($urandom_range(0, 6)));
            finish_transfer();
          end
        end
      end
    end
    if (stop_at == 5) return;
    // config header: total length mostly small, sometimes past the clamp
    d = random_octets(9);
    case ($urandom_range(0, 3))
      0:       total = $urandom_range(400, 600);
      1:       total = $urandom;
      default: total = $urandom_range(9, 60);
    endcase
    if (d.size() > 3) begin
      d[2] = total[7:0];
      d[3] = total[15:8];
    end
    send_octets(d);
    finish_transfer();
    if (stop_at == 6) return;
    // full config, truncated to a few bytes
    send_octets(random_octets($urandom_range(6, 12)));
    finish_transfer();
    if (stop_at == 7) return;
    // set configuration done
    finish_transfer();
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0:       begin gap_pct = 0;  stall_pct = 0;  end
      1:       begin gap_pct = 15; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 25; end
      default: begin gap_pct = 30; stall_pct = 30; end
    endcase
  endtask

  task automatic run_enumerations(int item_goal);
    while (items_sent < item_goal) begin
      pick_idling();
      enumerate_device();
    end
  endtask

  // Sender holds off until every expected result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (backlog != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int base;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    action        <= ACT_DATA;
    data_byte     <= '0;
    freed_address <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle items, release of zero and unused, restart, short transfers,
    // clamped config length
    send_item(ACT_DATA, 8'hFF, 7'h7F);
    send_item(ACT_COMPLETE, 8'h00, 7'h00);
    send_item(ACT_RELEASE, 8'h00, 7'h00);
    send_item(ACT_RELEASE, 8'hFF, 7'h7F);
    send_item(ACT_START, 8'h00, 7'h00);
    send_item(ACT_START, 8'hFF, 7'h7F);
    send_item(ACT_DATA, 8'h00, 7'h00);
    send_item(ACT_DATA, 8'hFF, 7'h7F);
    send_item(ACT_DATA, 8'h55, 7'h2A);
    send_item(ACT_DATA, 8'hAA, 7'h55);
    send_item(ACT_DATA, 8'h01, 7'h01);
    send_item(ACT_DATA, 8'h80, 7'h40);
    send_item(ACT_DATA, 8'h7F, 7'h3F);
    send_item(ACT_DATA, 8'hFE, 7'h7E);
    send_item(ACT_COMPLETE, 8'h00, 7'h00);
    send_item(ACT_START, 8'h00, 7'h00);
    send_item(ACT_COMPLETE, 8'h00, 7'h00);
    send_item(ACT_COMPLETE, 8'h00, 7'h00);
    send_item(ACT_COMPLETE, 8'h00, 7'h00);
    send_item(ACT_COMPLETE, 8'h00, 7'h00);
    send_item(ACT_COMPLETE, 8'h00, 7'h00);
    send_item(ACT_COMPLETE, 8'h00, 7'h00);
    send_item(ACT_RELEASE, 8'h00, 7'd1);
    send_item(ACT_RELEASE, 8'h00, 7'd2);

    // Random enumerations
    base = items_sent;
    run_enumerations(base + 30);
    wait_drained();

    // Take every address until the block runs out, then free some
    pick_idling();
    repeat (MAX_ADDRESS + 1) begin
      send_item(ACT_START, 8'($urandom), rnd_addr());
      send_item(ACT_COMPLETE, 8'($urandom), rnd_addr());
    end
    repeat (25) send_item(ACT_RELEASE, 8'($urandom), ADDR_W'($urandom_range(1, 127)));

    // Tail without idling: one long transfer, then a clean enumeration
    gap_pct   = 0;
    stall_pct = 0;
    send_item(ACT_START, 8'($urandom), rnd_addr());
    repeat (30) send_item(ACT_DATA, 8'($urandom), rnd_addr());
    send_item(ACT_COMPLETE, 8'($urandom), rnd_addr());
    enumerate_device();

    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && backlog == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
